/* rtl/pscf_pkg.sv */
// ----------------------------------------------------------------------------
// pscf_pkg
// Types and constants shared by the prefix capture filter modules.
// ----------------------------------------------------------------------------
package pscf_pkg;

   localparam logic [1:0]  OP_LOAD    = 2'd0;
   localparam logic [1:0]  OP_PACKET  = 2'd1;
   localparam logic [1:0]  OP_RELEASE = 2'd2;

   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [15:0] ETH_IPV6   = 16'h86DD;
   localparam logic [7:0]  CTL_PROTO  = 8'd146;

   localparam logic [47:0] TIMEOUT_RESET = 48'd3600000000;

   localparam logic [2:0] V_LOADED    = 3'd0;
   localparam logic [2:0] V_NOT_IP    = 3'd1;
   localparam logic [2:0] V_NO_MATCH  = 3'd2;
   localparam logic [2:0] V_QUEUED    = 3'd3;
   localparam logic [2:0] V_ACTIVATED = 3'd4;
   localparam logic [2:0] V_CAPTURE   = 3'd5;
   localparam logic [2:0] V_DISCARD   = 3'd6;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] frame_type;
      logic [7:0]  ip_proto;
      logic [63:0] lookup_key;
      logic [9:0]  entry_slot;
      logic        entry_is_ipv6;
      logic [47:0] now_ticks;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic [9:0] matched_slot;
      logic       prefix_active;
   } rsp_type;

   typedef enum logic [2:0] {
      CMD_LOAD,
      CMD_LOAD_SKIP,
      CMD_PKT,
      CMD_REL,
      CMD_REL_SKIP,
      CMD_NOT_IP,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         is_v6;
      logic         is_ctl;
      logic [63:0]  key;
      logic [9:0]   slot;
      logic [47:0]  now;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_APPLY,
      ST_REL_CHK
   } back_state_type;

endpackage

/* rtl/pscf_front.sv */
// ----------------------------------------------------------------------------
// pscf_front
// Accepts request beats, classifies them and normalizes the lookup key.
// ----------------------------------------------------------------------------
module pscf_front
   import pscf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024
) (
   input  req_type req_data,
   output cmd_type cmd
);

   logic in_range;

   // check the addressed slot against the table size
   assign in_range = (32'(req_data.entry_slot) < 32'(TABLE_ENTRIES));

   // classify the beat and build the key for the match
   always_comb begin
      cmd.is_v6  = 1'b0;
      cmd.is_ctl = (req_data.ip_proto == CTL_PROTO);
      cmd.key    = req_data.lookup_key;
      cmd.slot   = req_data.entry_slot;
      cmd.now    = req_data.now_ticks;
      cmd.kind   = CMD_BAD;
      case (req_data.opcode)
         OP_LOAD: begin
            cmd.is_v6 = req_data.entry_is_ipv6;
            cmd.kind  = in_range ? CMD_LOAD : CMD_LOAD_SKIP;
            if (!req_data.entry_is_ipv6) begin
               cmd.key = {32'd0, req_data.lookup_key[31:0]};
            end
         end
         OP_PACKET: begin
            if (req_data.frame_type == ETH_IPV4) begin
               cmd.kind = CMD_PKT;
               cmd.key  = {32'd0, req_data.lookup_key[31:0]};
            end else if (req_data.frame_type == ETH_IPV6) begin
               cmd.kind  = CMD_PKT;
               cmd.is_v6 = 1'b1;
               cmd.key   = {req_data.lookup_key[63:4], 4'd0};
            end else begin
               cmd.kind = CMD_NOT_IP;
            end
         end
         OP_RELEASE: begin
            cmd.kind = in_range ? CMD_REL : CMD_REL_SKIP;
         end
         default: begin
            cmd.kind = CMD_BAD;
         end
      endcase
   end

endmodule

/* rtl/pscf_queue.sv */
// ----------------------------------------------------------------------------
// pscf_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module pscf_queue
   import pscf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    q_valid,
   output cmd_type q_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_data  = slot_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/pscf_back.sv */
// ----------------------------------------------------------------------------
// pscf_back
// Executes commands against the prefix table memory and drives results.
// ----------------------------------------------------------------------------
module pscf_back
   import pscf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int TIME_BITS     = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   input  logic        q_valid,
   input  cmd_type     q_data,
   output logic        pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int POS_V = 0;
   localparam int POS_6 = 1;
   localparam int POS_A = 2;
   localparam int POS_K = 3;
   localparam int POS_T = 67;
   localparam int ENT_W = POS_T + TIME_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [ENT_W-1:0]     mem [TABLE_ENTRIES];
   logic [ENT_W-1:0]     rd_data_ff;
   back_state_type       state_ff, state_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [47:0]          timeout_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   logic                 mem_we;
   logic [IDX_W-1:0]     mem_wa;
   logic [ENT_W-1:0]     mem_wd;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 out_load;
   rsp_type              out_d;

   logic [IDX_W-1:0]     slot_addr;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] age;
   logic [63:0]          age64;
   logic                 expired;
   logic                 hit;
   logic                 new_act;

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_addr = IDX_W'(q_data.slot);
   assign now_t     = TIME_BITS'(64'(q_data.now));
   assign age       = now_t - rd_data_ff[POS_T +: TIME_BITS];
   assign age64     = 64'(age);
   assign expired   = age64 > 64'(timeout_ff);
   assign new_act   = rd_data_ff[POS_A] & ~expired;
   assign hit       = rd_data_ff[POS_V] && (rd_data_ff[POS_6] == q_data.is_v6)
                      && (rd_data_ff[POS_K +: 64] == q_data.key);

   // sequence the clearing pass, the scan and the entry update
   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      clr_in   = clr_ff;
      mem_we   = 1'b0;
      mem_wa   = scan_ff;
      mem_wd   = '0;
      rd_en    = 1'b0;
      rd_addr  = scan_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      out_d    = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               case (q_data.kind)
                  CMD_LOAD: begin
                     mem_we                  = 1'b1;
                     mem_wa                  = slot_addr;
                     mem_wd[POS_V]           = 1'b1;
                     mem_wd[POS_6]           = q_data.is_v6;
                     mem_wd[POS_K +: 64]     = q_data.key;
                     out_load                = 1'b1;
                     out_d                   = '{V_LOADED, q_data.slot, 1'b0};
                     pop                     = 1'b1;
                  end
                  CMD_LOAD_SKIP: begin
                     out_load = 1'b1;
                     out_d    = '{V_LOADED, q_data.slot, 1'b0};
                     pop      = 1'b1;
                  end
                  CMD_NOT_IP: begin
                     out_load = 1'b1;
                     out_d    = '{V_NOT_IP, 10'd0, 1'b0};
                     pop      = 1'b1;
                  end
                  CMD_REL_SKIP: begin
                     out_load = 1'b1;
                     out_d    = '{V_DISCARD, q_data.slot, 1'b0};
                     pop      = 1'b1;
                  end
                  CMD_REL: begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_addr;
                     state_in = ST_REL_CHK;
                  end
                  CMD_PKT: begin
                     scan_in  = LAST_IDX;
                     state_in = ST_SCAN_RD;
                  end
                  default: begin
                     out_load = 1'b1;
                     out_d    = '{V_DISCARD, 10'd0, 1'b0};
                     pop      = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = scan_ff;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (hit) begin
               state_in = ST_APPLY;
            end else if (scan_ff == '0) begin
               out_load = 1'b1;
               out_d    = '{V_NO_MATCH, 10'd0, 1'b0};
               pop      = 1'b1;
               state_in = ST_IDLE;
            end else begin
               scan_in  = scan_ff - 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_APPLY: begin
            mem_we   = 1'b1;
            mem_wa   = scan_ff;
            mem_wd   = rd_data_ff;
            out_load = 1'b1;
            pop      = 1'b1;
            state_in = ST_IDLE;
            if (q_data.is_ctl) begin
               mem_wd[POS_A]              = 1'b1;
               mem_wd[POS_T +: TIME_BITS] = now_t;
               out_d = '{V_ACTIVATED, 10'(scan_ff), 1'b1};
            end else begin
               mem_wd[POS_A] = new_act;
               out_d = '{V_QUEUED, 10'(scan_ff), new_act};
            end
         end
         ST_REL_CHK: begin
            out_load = 1'b1;
            pop      = 1'b1;
            state_in = ST_IDLE;
            if (!rd_data_ff[POS_V] || rd_data_ff[POS_A]) begin
               out_d = '{V_DISCARD, q_data.slot, rd_data_ff[POS_V] & rd_data_ff[POS_A]};
            end else begin
               out_d = '{V_CAPTURE, q_data.slot, 1'b0};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         scan_ff  <= scan_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         // drop the result once taken, load a new one
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold result payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= out_d;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

/* rtl/prefix_state_capture_filter_top.sv */
// Flow: load, non-IP and out-of-range items are answered straight from idle; a release
// first reads its entry; a packet item scans the table entries from the top slot down,
// one read and compare per entry through the one read port, until a hit or slot 0.
// Throughput: one item at a time in the back part; a two-beat queue decouples req.
// Reset: synchronous; a clearing pass over every table entry follows reset,
// during which req is stalled.
// ----------------------------------------------------------------------------
// prefix_state_capture_filter_top
// Per-prefix capture filter with a decoupled classify front and table back.
// ----------------------------------------------------------------------------
module prefix_state_capture_filter_top
   import pscf_pkg::*;
#(
   parameter int TABLE_ENTRIES = 1024,
   parameter int TIME_BITS     = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   cmd_type cmd;
   cmd_type q_data;
   logic    q_full;
   logic    q_valid;
   logic    pop;
   logic    clearing;
   logic    push;

   // stall while the queue is full or the table is being cleared
   assign req_stall = q_full | clearing;
   assign push      = req_valid & ~req_stall;

   pscf_front #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_front (
      .req_data(req_data),
      .cmd     (cmd)
   );

   pscf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(cmd),
      .full     (q_full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_data   (q_data)
   );

   pscf_back #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .TIME_BITS    (TIME_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_valid    (q_valid),
      .q_data     (q_data),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* test/pscf_checker.sv */
// ----------------------------------------------------------------------------
// pscf_checker
// Watches the req, rsp and csr ports of the prefix capture filter. It keeps its
// own copy of the prefix table and the timeout, works out the verdict for each
// accepted req beat, and compares each accepted rsp beat with the oldest one.
// ----------------------------------------------------------------------------
module pscf_checker
   import pscf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   output int          fail_count,
   output int          outstanding
);

   localparam int SLOTS = 1024;

   // shadow prefix table
   logic        tbl_valid  [SLOTS];
   logic        tbl_v6     [SLOTS];
   logic [63:0] tbl_key    [SLOTS];
   logic        tbl_active [SLOTS];
   logic [47:0] tbl_stamp  [SLOTS];
   logic [47:0] timeout_ticks;

   rsp_type verdict_q[$];

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Highest valid slot matching family and key, or -1.
   function automatic int lookup_slot(logic v6, logic [63:0] key);
      int hit;
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_valid[i] && tbl_v6[i] == v6 && tbl_key[i] == key)
            hit = i;
      return hit;
   endfunction

   // Apply one req beat to the shadow table and return its verdict.
   function automatic rsp_type classify(req_type r);
      rsp_type     o;
      int          hit;
      logic        v6;
      logic [63:0] k;
      o = '0;
      case (r.opcode)
         OP_LOAD: begin
            tbl_valid[r.entry_slot]  = 1'b1;
            tbl_v6[r.entry_slot]     = r.entry_is_ipv6;
            tbl_key[r.entry_slot]    = r.entry_is_ipv6 ? r.lookup_key
                                                       : {32'd0, r.lookup_key[31:0]};
            tbl_active[r.entry_slot] = 1'b0;
            tbl_stamp[r.entry_slot]  = '0;
            o.verdict      = V_LOADED;
            o.matched_slot = r.entry_slot;
         end
         OP_PACKET: begin
            if (r.frame_type == ETH_IPV4) begin
               v6 = 1'b0;
               k  = {32'd0, r.lookup_key[31:0]};
            end else if (r.frame_type == ETH_IPV6) begin
               v6 = 1'b1;
               k  = {r.lookup_key[63:4], 4'd0};
            end else begin
               o.verdict = V_NOT_IP;
               return o;
            end
            hit = lookup_slot(v6, k);
            if (hit < 0) begin
               o.verdict = V_NO_MATCH;
               return o;
            end
            o.matched_slot = hit[9:0];
            if (r.ip_proto == CTL_PROTO) begin
               tbl_active[hit] = 1'b1;
               tbl_stamp[hit]  = r.now_ticks;
               o.verdict       = V_ACTIVATED;
               o.prefix_active = 1'b1;
            end else begin
               // drop a stale activation before queuing
               if (48'(r.now_ticks - tbl_stamp[hit]) > timeout_ticks)
                  tbl_active[hit] = 1'b0;
               o.verdict       = V_QUEUED;
               o.prefix_active = tbl_active[hit];
            end
         end
         OP_RELEASE: begin
            o.matched_slot = r.entry_slot;
            if (!tbl_valid[r.entry_slot])
               o.verdict = V_DISCARD;
            else if (tbl_active[r.entry_slot]) begin
               o.verdict       = V_DISCARD;
               o.prefix_active = 1'b1;
            end else
               o.verdict = V_CAPTURE;
         end
         default: o.verdict = V_DISCARD;
      endcase
      return o;
   endfunction

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_v6[i]     = 1'b0;
            tbl_key[i]    = '0;
            tbl_active[i] = 1'b0;
            tbl_stamp[i]  = '0;
         end
         timeout_ticks = TIMEOUT_RESET;
         verdict_q.delete();
      end else begin
         if (csr_wr_en)
            timeout_ticks = csr_wr_data;
         // compare a rsp beat with the oldest verdict
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0)
               report("unexpected rsp beat, verdict", 16'(rsp_data.verdict), 16'hFFFF);
            else begin
               want = verdict_q.pop_front();
               if (rsp_data.verdict !== want.verdict)
                  report("verdict", 16'(rsp_data.verdict), 16'(want.verdict));
               if (rsp_data.matched_slot !== want.matched_slot)
                  report("matched_slot", 16'(rsp_data.matched_slot),
                         16'(want.matched_slot));
               if (rsp_data.prefix_active !== want.prefix_active)
                  report("prefix_active", 16'(rsp_data.prefix_active),
                         16'(want.prefix_active));
            end
         end
         // predict a req beat
         if (req_valid && !req_stall)
            verdict_q.push_back(classify(req_data));
      end
      outstanding = verdict_q.size();
   end

endmodule

/* test/tb_prefix_state_capture_filter_top.sv */
// ----------------------------------------------------------------------------
// tb_prefix_state_capture_filter_top
// Drives the prefix capture filter with a directed sequence and then random
// phases of loads, control and data packets and releases, under several
// timeout settings and idle patterns; pscf_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_prefix_state_capture_filter_top;
   import pscf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 300;
   localparam int POOL_MAX       = 32;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [47:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;

   int          fail_count;
   int          outstanding;
   int          idle_pct;
   int          stall_pct;
   int          hold_seq;
   int          hold_seen;
   int          hold_left;
   int          quiet_cycles;
   logic [47:0] now_base;
   logic [63:0] pool_key [POOL_MAX];
   logic        pool_v6  [POOL_MAX];
   int          pool_size;

   prefix_state_capture_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   pscf_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rsp stall: random, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // watchdog: end the run if no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // Offer one req beat after a random idle gap; return once accepted.
   task automatic send(req_type r);
      logic stalled;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
   endtask

   task automatic send_load(logic [9:0] slot, logic v6, logic [63:0] key);
      req_type r;
      r = '0;
      r.opcode        = OP_LOAD;
      r.entry_slot    = slot;
      r.entry_is_ipv6 = v6;
      r.lookup_key    = key;
      r.now_ticks     = now_base;
      send(r);
   endtask

   task automatic send_packet(logic [15:0] eth, logic [7:0] proto, logic [63:0] key);
      req_type r;
      r = '0;
      r.opcode     = OP_PACKET;
      r.frame_type = eth;
      r.ip_proto   = proto;
      r.lookup_key = key;
      r.now_ticks  = now_base;
      send(r);
   endtask

   task automatic send_release(logic [9:0] slot);
      req_type r;
      r = '0;
      r.opcode     = OP_RELEASE;
      r.entry_slot = slot;
      r.now_ticks  = now_base;
      send(r);
   endtask

   // Wait until every verdict is back and the block has settled.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_timeout(logic [47:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [9:0] pick_slot();
      if ($urandom_range(9) == 0)
         return 10'($urandom_range(1023));
      return 10'($urandom_range(1023, 992));
   endfunction

   // One random item, mostly well-formed traffic against loaded prefixes.
   task automatic send_random();
      req_type     r;
      int          sel;
      int          p;
      logic [63:0] key;
      logic        v6;
      sel = $urandom_range(99);
      r = req_type'(149'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if ($urandom_range(19) == 0)
         r.now_ticks = {16'($urandom), 32'($urandom)};
      else begin
         now_base    = now_base + 48'($urandom_range(700));
         r.now_ticks = now_base;
      end
      if (sel < 15 || pool_size == 0) begin
         v6  = 1'($urandom);
         key = {$urandom, $urandom};
         if (pool_size > 0 && $urandom_range(2) == 0) begin
            p   = $urandom_range(pool_size - 1);
            key = pool_key[p];
            v6  = pool_v6[p];
         end else if (v6 && $urandom_range(4) != 0)
            key[3:0] = 4'd0;
         r.opcode        = OP_LOAD;
         r.entry_slot    = pick_slot();
         r.entry_is_ipv6 = v6;
         r.lookup_key    = key;
         if (pool_size < POOL_MAX) begin
            pool_key[pool_size] = key;
            pool_v6[pool_size]  = v6;
            pool_size++;
         end else begin
            p = $urandom_range(POOL_MAX - 1);
            pool_key[p] = key;
            pool_v6[p]  = v6;
         end
      end else if (sel < 60) begin
         r.opcode = OP_PACKET;
         p = $urandom_range(9);
         if (p == 0) begin
            // random ethertype, almost never IP
         end else if (p == 1)
            r.frame_type = $urandom_range(1) ? ETH_IPV4 : ETH_IPV6;
         else begin
            p = $urandom_range(pool_size - 1);
            r.frame_type = pool_v6[p] ? ETH_IPV6 : ETH_IPV4;
            r.lookup_key = pool_v6[p] ? {pool_key[p][63:4], 4'($urandom)}
                                      : {32'($urandom), pool_key[p][31:0]};
         end
         if ($urandom_range(2) == 0)
            r.ip_proto = CTL_PROTO;
      end else if (sel < 95) begin
         r.opcode     = OP_RELEASE;
         r.entry_slot = pick_slot();
      end else
         r.opcode = 2'd3;
      send(r);
   endtask

   initial begin
      req_type bad;
      logic [47:0] timeouts [6];
      int          sidle    [6];
      int          rstall   [6];
      timeouts = '{TIMEOUT_RESET, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd1000, 48'd50,
                   TIMEOUT_RESET};
      sidle    = '{0, 48, 0, 13, 0, 48};
      rstall   = '{0, 0, 48, 13, 0, 0};
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_data    = '0;
      idle_pct    = 0;
      stall_pct   = 0;
      hold_seq    = 0;
      pool_size   = 0;
      now_base    = 48'd1000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: table extremes, both families, every verdict
      send_load(10'd1023, 1'b0, 64'hDEAD_BEEF_0A00_0001);
      send_load(10'd1022, 1'b1, 64'h2001_0DB8_0000_0000);
      send_load(10'd1021, 1'b1, 64'h2001_0DB8_0000_0105);
      send_load(10'd1000, 1'b0, 64'h0000_0000_0A00_0001);
      send_load(10'd0,    1'b0, 64'h0);
      send_load(10'd1010, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0);
      send_packet(ETH_IPV4, 8'd6, 64'h0000_0000_0A00_0001);
      send_packet(ETH_IPV4, CTL_PROTO, 64'hFFFF_FFFF_0A00_0001);
      send_release(10'd1023);
      send_packet(ETH_IPV6, 8'd17, 64'h2001_0DB8_0000_000F);
      send_packet(ETH_IPV6, CTL_PROTO, 64'h2001_0DB8_0000_0105);
      send_packet(ETH_IPV6, CTL_PROTO, 64'hFFFF_FFFF_FFFF_FFFF);
      send_release(10'd1022);
      send_release(10'd5);
      send_packet(16'h86DC, CTL_PROTO, 64'h0);
      send_packet(16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(ETH_IPV4, 8'd0, 64'h0);
      send_packet(ETH_IPV4, 8'd255, 64'h1234);
      bad = '1;
      send(bad);
      send_load(10'd1023, 1'b0, 64'h0000_0000_C0A8_0101);
      send_release(10'd1023);
      now_base = now_base + 48'd10000;
      send_packet(ETH_IPV6, 8'd6, 64'hFFFF_FFFF_FFFF_FFF3);
      send_release(10'd1010);

      // random phases, each under its own timeout and idle pattern
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0)
            write_timeout(timeouts[ph]);
         if (ph == 4)
            now_base = 48'hFFFF_FFFF_E000;
         idle_pct  = sidle[ph];
         stall_pct = rstall[ph];
         for (int n = 0; n < 125; n++) begin
            if (ph == 4 && n == 40)
               hold_seq++;
            if (ph == 5 && n == 60)
               drain();
            send_random();
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* filelist.f */
rtl/pscf_pkg.sv
rtl/pscf_front.sv
rtl/pscf_queue.sv
rtl/pscf_back.sv
rtl/prefix_state_capture_filter_top.sv
test/pscf_checker.sv
test/tb_prefix_state_capture_filter_top.sv
